/* hw/rtl/carv_pkg.sv */
package carv_pkg;

   localparam int CombMax = 8;
   localparam int DiffMax = 4;
   localparam int GainOne = 32768;
   localparam int CombTotal = 11024;
   localparam int DiffTotal = 1563;

   typedef enum logic [1:0] {
      CSR_ENABLE = 2'd0,
      CSR_ROOM   = 2'd1,
      CSR_DAMP   = 2'd2,
      CSR_WET    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_C_RD,
      ST_C_MUL,
      ST_C_LP,
      ST_C_FB,
      ST_C_WR,
      ST_ACC,
      ST_D_RD,
      ST_D_T,
      ST_D_WR,
      ST_MIX_A,
      ST_MIX_B,
      ST_MIX_C,
      ST_OUT
   } state_type;

   // Comb line length and base address in the shared store
   function automatic logic [10:0] comb_len(input logic [2:0] i);
      case (i)
         3'd0: comb_len = 11'd1557;
         3'd1: comb_len = 11'd1617;
         3'd2: comb_len = 11'd1491;
         3'd3: comb_len = 11'd1422;
         3'd4: comb_len = 11'd1277;
         3'd5: comb_len = 11'd1356;
         3'd6: comb_len = 11'd1188;
         default: comb_len = 11'd1116;
      endcase
   endfunction

   function automatic logic [13:0] comb_base(input logic [2:0] i);
      case (i)
         3'd0: comb_base = 14'd0;
         3'd1: comb_base = 14'd1557;
         3'd2: comb_base = 14'd3174;
         3'd3: comb_base = 14'd4665;
         3'd4: comb_base = 14'd6087;
         3'd5: comb_base = 14'd7364;
         3'd6: comb_base = 14'd8720;
         default: comb_base = 14'd9908;
      endcase
   endfunction

   function automatic logic [9:0] diff_len(input logic [1:0] i);
      case (i)
         2'd0: diff_len = 10'd225;
         2'd1: diff_len = 10'd556;
         2'd2: diff_len = 10'd441;
         default: diff_len = 10'd341;
      endcase
   endfunction

   function automatic logic [10:0] diff_base(input logic [1:0] i);
      case (i)
         2'd0: diff_base = 11'd0;
         2'd1: diff_base = 11'd225;
         2'd2: diff_base = 11'd781;
         default: diff_base = 11'd1222;
      endcase
   endfunction

   function automatic logic [15:0] clamp_gain(input logic [15:0] g);
      clamp_gain = (g > 16'(GainOne)) ? 16'(GainOne) : g;
   endfunction

endpackage

/* hw/rtl/comb_allpass_reverb_unit.sv */
// Channel  | Ports                    | Word
// req      | req_tvalid/tready/tdata  | [SAMPLE_WIDTH-1:0] sample_in
// rsp      | rsp_tvalid/tready/tdata  | [SAMPLE_WIDTH-1:0] sample_out
// csr      | csr_valid/ready/index/data | 2-bit index, 16-bit data
// A word is processed by one read-modify-write pass per line through the
// single-port stores before the next word is accepted. Bypass words skip the
// line passes. After reset a clearing pass zeroes the stores; no word is
// accepted meanwhile. A result waits in the output register while the next
// word is taken and processed.
module comb_allpass_reverb_unit #(
   parameter int COMB_COUNT = 8,
   parameter int DIFFUSER_COUNT = 4,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SAMPLE_WIDTH-1:0] req_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [SAMPLE_WIDTH-1:0] rsp_tdata,   // [SAMPLE_WIDTH-1:0] sample_out
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_data
);
   import carv_pkg::*;

   localparam int W = SAMPLE_WIDTH;
   localparam int PW = W + 18;
   localparam logic signed [PW-1:0] SMax = PW'((64'sd1 <<< (W - 1)) - 1);
   localparam logic signed [PW-1:0] SMin = -SMax - PW'(1);

   function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
      if (v > SMax) sat = W'(SMax);
      else if (v < SMin) sat = W'(SMin);
      else sat = W'(v);
   endfunction

   function automatic logic signed [PW-1:0] rsh(input logic signed [PW-1:0] v,
                                                input int s);
      rsh = (v + ($signed(PW'(1)) <<< (s - 1))) >>> s;
   endfunction

   // configuration
   logic enable_ff;
   logic [15:0] room_ff, damp_ff, wet_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         room_ff <= 16'd16384;
         damp_ff <= 16'd16384;
         wet_ff <= 16'd9830;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE: enable_ff <= csr_data[0];
            CSR_ROOM:   room_ff <= csr_data;
            CSR_DAMP:   damp_ff <= csr_data;
            CSR_WET:    wet_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // stores
   logic [W-1:0] comb_mem [CombTotal];
   logic [W-1:0] diff_mem [DiffTotal];
   logic [13:0] c_addr;
   logic [10:0] d_addr;
   logic c_we, d_we;
   logic [W-1:0] c_wdata, d_wdata, c_rdata_ff, d_rdata_ff;
   always_ff @(posedge clock) begin
      if (c_we) comb_mem[c_addr] <= c_wdata;
      c_rdata_ff <= comb_mem[c_addr];
   end
   always_ff @(posedge clock) begin
      if (d_we) diff_mem[d_addr] <= d_wdata;
      d_rdata_ff <= diff_mem[d_addr];
   end

   // per-line positions and lowpass
   logic [10:0] cpos_ff [CombMax];
   logic [W-1:0] lp_ff [CombMax];
   logic [9:0] dpos_ff [DiffMax];

   state_type state_ff, state_in;
   logic [13:0] clr_ff, clr_in;
   logic [2:0] ci_ff, ci_in;
   logic [1:0] di_ff, di_in;
   logic signed [W-1:0] x_ff, x_in, acc_ff, acc_in, b_ff, b_in, t_ff, t_in;
   logic signed [W-1:0] lp_new_ff, lp_new_in;
   logic signed [W+3:0] sum_ff, sum_in;
   logic signed [PW-1:0] p0_ff, p0_in, p1_ff, p1_in;
   logic rv_ff, rv_in;
   logic [W-1:0] rd_ff, rd_in;
   logic [10:0] cp_cur, cp_nxt;
   logic [9:0] dp_cur, dp_nxt;
   logic [15:0] g, d, w;
   logic cpos_we, lp_we, dpos_we;

   always_comb begin
      g = clamp_gain(room_ff);
      d = clamp_gain(damp_ff);
      w = clamp_gain(wet_ff);
      cp_cur = (cpos_ff[ci_ff] >= comb_len(ci_ff)) ? 11'd0 : cpos_ff[ci_ff];
      cp_nxt = (cp_cur + 11'd1 >= comb_len(ci_ff)) ? 11'd0 : cp_cur + 11'd1;
      dp_cur = (dpos_ff[di_ff] >= diff_len(di_ff)) ? 10'd0 : dpos_ff[di_ff];
      dp_nxt = (dp_cur + 10'd1 >= diff_len(di_ff)) ? 10'd0 : dp_cur + 10'd1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      ci_in = ci_ff;
      di_in = di_ff;
      x_in = x_ff;
      acc_in = acc_ff;
      b_in = b_ff;
      t_in = t_ff;
      lp_new_in = lp_new_ff;
      sum_in = sum_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      rv_in = rv_ff;
      rd_in = rd_ff;
      req_tready = 1'b0;
      c_addr = comb_base(ci_ff) + 14'(cp_cur);
      d_addr = diff_base(di_ff) + 11'(dp_cur);
      c_we = 1'b0;
      d_we = 1'b0;
      c_wdata = x_ff;
      d_wdata = t_ff;
      cpos_we = 1'b0;
      lp_we = 1'b0;
      dpos_we = 1'b0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            c_addr = clr_ff;
            c_we = 1'b1;
            c_wdata = '0;
            d_addr = clr_ff[10:0];
            d_we = (clr_ff < 14'(DiffTotal));
            d_wdata = '0;
            clr_in = clr_ff + 14'd1;
            if (clr_ff == 14'(CombTotal - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               x_in = req_tdata;
               if (!enable_ff) begin
                  state_in = ST_OUT;
                  acc_in = req_tdata;
               end else begin
                  ci_in = '0;
                  di_in = '0;
                  sum_in = '0;
                  state_in = ST_C_RD;
               end
            end
         end
         ST_C_RD: state_in = ST_C_MUL;
         ST_C_MUL: begin
            b_in = c_rdata_ff;
            sum_in = sum_ff + (W+4)'($signed(c_rdata_ff));
            p0_in = $signed(c_rdata_ff) * $signed({1'b0, 17'(GainOne) - 17'(d)});
            p1_in = $signed(lp_ff[ci_ff]) * $signed({1'b0, d});
            state_in = ST_C_LP;
         end
         ST_C_LP: begin
            lp_new_in = sat(rsh(p0_ff + p1_ff, 15));
            state_in = ST_C_FB;
         end
         ST_C_FB: begin
            lp_we = 1'b1;
            p0_in = lp_new_ff * $signed({1'b0, g});
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            c_we = 1'b1;
            c_wdata = sat(PW'(x_ff) + rsh(p0_ff, 15));
            cpos_we = 1'b1;
            if (32'(ci_ff) == COMB_COUNT - 1) state_in = ST_ACC;
            else begin
               ci_in = ci_ff + 3'd1;
               state_in = ST_C_RD;
            end
         end
         ST_ACC: begin
            acc_in = sat(rsh(PW'(sum_ff), 3));
            state_in = ST_D_RD;
         end
         ST_D_RD: state_in = ST_D_T;
         ST_D_T: begin
            b_in = d_rdata_ff;
            t_in = sat(PW'(acc_ff) + rsh(PW'($signed(d_rdata_ff)), 1));
            state_in = ST_D_WR;
         end
         ST_D_WR: begin
            d_we = 1'b1;
            dpos_we = 1'b1;
            acc_in = sat(PW'(b_ff) - rsh(PW'(t_ff), 1));
            if (32'(di_ff) == DIFFUSER_COUNT - 1) state_in = ST_MIX_A;
            else begin
               di_in = di_ff + 2'd1;
               state_in = ST_D_RD;
            end
         end
         ST_MIX_A: begin
            p0_in = x_ff * $signed({1'b0, 17'(GainOne) - 17'(w)});
            p1_in = acc_ff * $signed({1'b0, w});
            state_in = ST_MIX_B;
         end
         ST_MIX_B: begin
            acc_in = sat(rsh(p0_ff + p1_ff, 15));
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // wait for output register to free
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = acc_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rv_ff <= 1'b0;
         for (int i = 0; i < CombMax; i++) begin
            cpos_ff[i] <= '0;
            lp_ff[i] <= '0;
         end
         for (int i = 0; i < DiffMax; i++) dpos_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rv_ff <= rv_in;
         if (cpos_we) cpos_ff[ci_ff] <= cp_nxt;
         if (lp_we) lp_ff[ci_ff] <= lp_new_ff;
         if (dpos_we) dpos_ff[di_ff] <= dp_nxt;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff <= ci_in;
      di_ff <= di_in;
      x_ff <= x_in;
      acc_ff <= acc_in;
      b_ff <= b_in;
      t_ff <= t_in;
      lp_new_ff <= lp_new_in;
      sum_ff <= sum_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      rd_ff <= rd_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;

endmodule
